### src/dcre_pkg.sv
// ----------------------------------------------------------------------------
// dcre_pkg: shared constants and types for the rise event extractor
// Delay line geometry, field widths and reset values used by the extractor and its bench.
// ----------------------------------------------------------------------------
`default_nettype none

package dcre_pkg;

    localparam int LINE_DEPTH = 32;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int PTR_W      = ADDR_W + 1;

    localparam int TAPS_W     = 5;
    localparam int SAMPLE_W   = 16;
    localparam int INDEX_W    = 32;
    localparam int LEN_W      = 16;

    localparam logic [TAPS_W-1:0] TAPS_RESET = 5'd10;
    localparam logic [LEN_W-1:0]  LEN_MAX    = '1;

    typedef logic [ADDR_W-1:0]          t_addr;
    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [INDEX_W-1:0]         t_index;
    typedef logic [LEN_W-1:0]           t_len;
    typedef logic [TAPS_W-1:0]          t_taps;

endpackage

`default_nettype wire

### src/dcre_ram.sv
// ----------------------------------------------------------------------------
// dcre_ram: generic simple dual-port RAM
// One write port, one read port with enable and registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dcre_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // hold the last read word while the port is idle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### src/delayed_compare_rise_event_extractor.sv
// ----------------------------------------------------------------------------
// delayed_compare_rise_event_extractor: rise event detector on a sample stream
// Compares each sample with the one delay_taps earlier and reports closed rises.
// ----------------------------------------------------------------------------
// The block takes one sample per clock cycle, back to back, while the output
// side does not stall, and loads the result word into the output register
// when stage 1 advances with the closing sample. Accept writes the sample into
// the delay line RAM and reads the older sample at the same edge; the
// registered read data is then compared with the stage 1 sample, and the edge
// that advances stage 1 updates the run and loads the output register. A
// stalled output holds the stage behind it and so the input. The first
// delay_taps samples only fill the line. A write of delay_taps is meant for an
// idle block.
`default_nettype none

module delayed_compare_rise_event_extractor (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [dcre_pkg::TAPS_W-1:0]         i_cfg_wr_data,
    input  wire logic                                i_sample_valid,
    output logic                                     o_sample_ready,
    input  wire logic signed [dcre_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                     o_event_valid,
    input  wire logic                                i_event_ready,
    output logic      [dcre_pkg::INDEX_W-1:0]        o_sample_index,
    output logic      [dcre_pkg::LEN_W-1:0]          o_rise_length,
    output logic signed [dcre_pkg::SAMPLE_W-1:0]     o_start_level,
    output logic signed [dcre_pkg::SAMPLE_W-1:0]     o_end_level
);

    // configuration
    dcre_pkg::t_taps   r_taps;

    // input side state
    dcre_pkg::t_index  r_count;
    dcre_pkg::t_addr   r_wr_pos;
    logic              r_primed;

    // stage 1 word, waiting for the delayed sample
    logic              r_s1_valid;
    dcre_pkg::t_sample r_s1_sample;
    dcre_pkg::t_index  r_s1_index;
    logic              r_s1_primed;
    logic              r_s1_self;

    // open rise
    logic              r_armed;
    dcre_pkg::t_len    r_run_len;
    dcre_pkg::t_sample r_run_start;

    // output register
    logic              r_out_valid;
    dcre_pkg::t_index  r_out_index;
    dcre_pkg::t_len    r_out_len;
    dcre_pkg::t_sample r_out_start;
    dcre_pkg::t_sample r_out_end;

    logic              w_accept;
    logic              w_adv;
    logic              w_rising;
    logic              w_emit;
    logic              w_primed;
    dcre_pkg::t_addr   w_dist;
    dcre_pkg::t_addr   w_rd_addr;
    logic [dcre_pkg::PTR_W-1:0] w_rd_ptr;
    logic [dcre_pkg::SAMPLE_W-1:0] w_old_raw;
    dcre_pkg::t_sample w_old;

    // distance, capped at one below the line length
    always_comb begin
        if (32'(r_taps) > 32'(dcre_pkg::LINE_DEPTH - 1)) begin
            w_dist = dcre_pkg::ADDR_W'(dcre_pkg::LINE_DEPTH - 1);
        end else begin
            w_dist = dcre_pkg::ADDR_W'(r_taps);
        end
    end

    always_comb begin
        if (r_wr_pos >= w_dist) begin
            w_rd_ptr = dcre_pkg::PTR_W'(r_wr_pos) - dcre_pkg::PTR_W'(w_dist);
        end else begin
            w_rd_ptr = dcre_pkg::PTR_W'(r_wr_pos) + dcre_pkg::PTR_W'(dcre_pkg::LINE_DEPTH)
                     - dcre_pkg::PTR_W'(w_dist);
        end
    end
    assign w_rd_addr = w_rd_ptr[dcre_pkg::ADDR_W-1:0];
    assign w_primed  = r_primed || (r_count >= 32'(w_dist));

    // stage 1 moves on only when the output register has room
    assign w_adv          = r_s1_valid && (!r_out_valid || i_event_ready);
    assign o_sample_ready = !r_s1_valid || w_adv;
    assign w_accept       = i_sample_valid && o_sample_ready;

    dcre_ram #(
        .WIDTH (dcre_pkg::SAMPLE_W),
        .DEPTH (dcre_pkg::LINE_DEPTH)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept),
        .i_wr_addr (r_wr_pos),
        .i_wr_data (i_sample),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_old_raw)
    );

    assign w_old = $signed(w_old_raw);

    // zero distance compares the sample with itself, so it never rises
    assign w_rising = !r_s1_self && (r_s1_sample > w_old);
    assign w_emit   = r_s1_primed && !w_rising && r_armed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps <= dcre_pkg::TAPS_RESET;
        end else if (i_cfg_wr_en) begin
            r_taps <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_wr_pos   <= '0;
            r_primed   <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count  <= r_count + 32'd1;
                r_primed <= w_primed;
                // the index wrap lands on line position zero
                if (r_count == '1 ||
                    r_wr_pos == dcre_pkg::ADDR_W'(dcre_pkg::LINE_DEPTH - 1)) begin
                    r_wr_pos <= '0;
                end else begin
                    r_wr_pos <= r_wr_pos + dcre_pkg::ADDR_W'(1);
                end
                r_s1_valid <= 1'b1;
            end else if (w_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_sample <= i_sample;
            r_s1_index  <= r_count;
            r_s1_primed <= w_primed;
            r_s1_self   <= (w_dist == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed     <= 1'b0;
            r_run_len   <= '0;
            r_run_start <= '0;
        end else if (w_adv && r_s1_primed) begin
            if (w_rising) begin
                if (!r_armed) begin
                    r_run_start <= r_s1_sample;
                    r_armed     <= 1'b1;
                end
                if (r_run_len != dcre_pkg::LEN_MAX) begin
                    r_run_len <= r_run_len + dcre_pkg::LEN_W'(1);
                end
            end else if (r_armed) begin
                r_armed     <= 1'b0;
                r_run_len   <= '0;
                r_run_start <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_event_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_out_index <= r_s1_index;
            r_out_len   <= r_run_len;
            r_out_start <= r_run_start;
            r_out_end   <= r_s1_sample;
        end
    end

    assign o_event_valid  = r_out_valid;
    assign o_sample_index = r_out_index;
    assign o_rise_length  = r_out_len;
    assign o_start_level  = r_out_start;
    assign o_end_level    = r_out_end;

    // a word can only be blocked by a full, stalled output register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_sample_ready |-> (r_s1_valid && r_out_valid && !i_event_ready))
        else $error("input stalled without an output stall");

    // closing a rise clears the open run
    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_emit) |=> (!r_armed && r_run_len == '0))
        else $error("run state not cleared after a result");

    // a reported rise holds at least one rising sample
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_event_valid |-> (o_rise_length != '0))
        else $error("result with zero rise length");

    // warm-up, once done, stays done
    a_primed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_primed |=> r_primed)
        else $error("primed flag dropped");

endmodule

`default_nettype wire

### test/delayed_compare_rise_event_extractor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delayed_compare_rise_event_extractor_tb: self-checking bench for the rise
// event extractor
// A queue-fed driver streams samples through the valid/ready port. A shadow
// copy of the delay line and the run state predicts every closed rise. A
// monitor checks each event word field by field against the oldest
// prediction. The run walks through several tap distances and flow patterns.
// ----------------------------------------------------------------------------

module delayed_compare_rise_event_extractor_tb;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_PRINTED    = 40;

    typedef enum {FLOW_FREE, FLOW_SEND_IDLE, FLOW_RECV_STALL, FLOW_BOTH} t_flow_mode;

    typedef struct packed {
        dcre_pkg::t_index  sample_index;
        dcre_pkg::t_len    rise_length;
        dcre_pkg::t_sample start_level;
        dcre_pkg::t_sample end_level;
    } t_rise_event;

    logic                                 i_clk;
    logic                                 i_rst_n        = 1'b0;
    logic                                 i_cfg_wr_en    = 1'b0;
    logic [dcre_pkg::TAPS_W-1:0]          i_cfg_wr_data  = '0;
    logic                                 i_sample_valid = 1'b0;
    logic                                 o_sample_ready;
    logic signed [dcre_pkg::SAMPLE_W-1:0] i_sample       = '0;
    logic                                 o_event_valid;
    logic                                 i_event_ready  = 1'b0;
    logic [dcre_pkg::INDEX_W-1:0]         o_sample_index;
    logic [dcre_pkg::LEN_W-1:0]           o_rise_length;
    logic signed [dcre_pkg::SAMPLE_W-1:0] o_start_level;
    logic signed [dcre_pkg::SAMPLE_W-1:0] o_end_level;

    delayed_compare_rise_event_extractor i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sample       (i_sample),
        .o_event_valid  (o_event_valid),
        .i_event_ready  (i_event_ready),
        .o_sample_index (o_sample_index),
        .o_rise_length  (o_rise_length),
        .o_start_level  (o_start_level),
        .o_end_level    (o_end_level)
    );

    always begin
        i_clk = 1'b0;
        #(CLK_PERIOD / 2);
        i_clk = 1'b1;
        #(CLK_PERIOD / 2);
    end

    // Stimulus and expectations
    dcre_pkg::t_sample pending_samples[$];
    t_rise_event       expected_rises[$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit sample_taken  = 1'b0;

    int mismatch_count = 0;
    int samples_taken  = 0;
    int events_checked = 0;
    int settings_used  = 0;
    int idle_cycles    = 0;
    int longest_rise   = 0;

    // Shadow state of the block
    dcre_pkg::t_sample shadow_line [dcre_pkg::LINE_DEPTH];
    dcre_pkg::t_index  shadow_count;
    bit                shadow_primed;
    dcre_pkg::t_len    shadow_run_len;
    dcre_pkg::t_sample shadow_run_start;
    bit                shadow_armed;
    dcre_pkg::t_taps   shadow_taps;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
    endtask

    task automatic clear_shadow();
        foreach (shadow_line[k]) shadow_line[k] = '0;
        shadow_count     = '0;
        shadow_primed    = 1'b0;
        shadow_run_len   = '0;
        shadow_run_start = '0;
        shadow_armed     = 1'b0;
        shadow_taps      = dcre_pkg::TAPS_RESET;
    endtask

    // Advance the shadow state by one sample; queue the event word if it
    // closes an open rise.
    task automatic predict_rise_close(input dcre_pkg::t_sample s);
        int                tap_dist;
        dcre_pkg::t_addr   wr_pos;
        dcre_pkg::t_addr   rd_pos;
        dcre_pkg::t_sample older;
        t_rise_event       ev;
        tap_dist = (int'(shadow_taps) > dcre_pkg::LINE_DEPTH - 1) ?
                   dcre_pkg::LINE_DEPTH - 1 : int'(shadow_taps);
        wr_pos = shadow_count[dcre_pkg::ADDR_W-1:0];
        rd_pos = wr_pos - dcre_pkg::t_addr'(tap_dist);
        if (!shadow_primed && shadow_count >= dcre_pkg::t_index'(tap_dist)) begin
            shadow_primed = 1'b1;
        end
        shadow_line[wr_pos] = s;
        older = shadow_line[rd_pos];
        if (shadow_primed) begin
            if (s > older) begin
                if (!shadow_armed) begin
                    shadow_run_start = s;
                    shadow_armed     = 1'b1;
                end
                if (shadow_run_len != dcre_pkg::LEN_MAX) begin
                    shadow_run_len = shadow_run_len + 1'b1;
                end
            end else if (shadow_armed) begin
                ev.sample_index = shadow_count;
                ev.rise_length  = shadow_run_len;
                ev.start_level  = shadow_run_start;
                ev.end_level    = s;
                expected_rises.push_back(ev);
                shadow_run_len   = '0;
                shadow_run_start = '0;
                shadow_armed     = 1'b0;
            end
        end
        shadow_count = shadow_count + 1'b1;
    endtask

    // Sample side: present the next word at the falling edge once the last
    // one has gone.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_sample_valid <= 1'b0;
        end else if (!i_sample_valid || sample_taken) begin
            if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_sample_valid <= 1'b1;
                i_sample       <= pending_samples.pop_front();
            end else begin
                i_sample_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_event_ready <= 1'b0;
        end else begin
            i_event_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Monitor, predictor update and watchdog
    always @(posedge i_clk) begin
        t_rise_event ev;
        bit          event_taken;
        sample_taken = i_sample_valid && o_sample_ready;
        event_taken  = o_event_valid && i_event_ready;
        if (!i_rst_n) begin
            clear_shadow();
            idle_cycles = 0;
        end else begin
            if (i_cfg_wr_en) begin
                shadow_taps = i_cfg_wr_data;
            end
            if (sample_taken) begin
                samples_taken++;
                predict_rise_close(i_sample);
            end
            if (event_taken) begin
                if (expected_rises.size() == 0) begin
                    report_mismatch($sformatf("event word at index %0d with none pending",
                                              o_sample_index));
                end else begin
                    ev = expected_rises.pop_front();
                    events_checked++;
                    if (int'(ev.rise_length) > longest_rise) begin
                        longest_rise = int'(ev.rise_length);
                    end
                    if (o_sample_index !== ev.sample_index)
                        report_mismatch($sformatf("sample_index %0d, want %0d",
                                                  o_sample_index, ev.sample_index));
                    if (o_rise_length !== ev.rise_length)
                        report_mismatch($sformatf("rise_length %0d, want %0d (index %0d)",
                                                  o_rise_length, ev.rise_length,
                                                  ev.sample_index));
                    if (o_start_level !== ev.start_level)
                        report_mismatch($sformatf("start_level %0d, want %0d (index %0d)",
                                                  o_start_level, $signed(ev.start_level),
                                                  ev.sample_index));
                    if (o_end_level !== ev.end_level)
                        report_mismatch($sformatf("end_level %0d, want %0d (index %0d)",
                                                  o_end_level, $signed(ev.end_level),
                                                  ev.sample_index));
                end
            end
            if (sample_taken || event_taken) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no word moved for %0d cycles, %0d events outstanding",
                         idle_cycles, expected_rises.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic set_flow(input t_flow_mode mode);
        case (mode)
            FLOW_FREE: begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            FLOW_SEND_IDLE: begin
                send_idle_pct = 48;
                stall_pct     = 0;
            end
            FLOW_RECV_STALL: begin
                send_idle_pct = 0;
                stall_pct     = 48;
            end
            default: begin
                send_idle_pct = 11;
                stall_pct     = 11;
            end
        endcase
    endtask

    // Hold until every word has gone and every event has come back, then let
    // the pipeline drain.
    task automatic settle();
        while (pending_samples.size() != 0 || i_sample_valid || expected_rises.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_taps(input dcre_pkg::t_taps d);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= d;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        settings_used++;
    endtask

    // Mostly rising ramps and flat stretches, with extremes and raw noise.
    task automatic queue_random_samples(input int n, input int d);
        int count;
        int len;
        int step;
        int v;
        count = 0;
        while (count < n) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    len  = $urandom_range(1, 2 * d + 2);
                    step = $urandom_range(1, 300);
                    v    = int'(dcre_pkg::t_sample'($urandom));
                    for (int k = 0; k < len && count < n; k++) begin
                        pending_samples.push_back(dcre_pkg::t_sample'(v));
                        v = (v + step > 32767) ? 32767 : v + step;
                        count++;
                    end
                end
                4, 5: begin
                    len = $urandom_range(1, d + 2);
                    v   = int'(dcre_pkg::t_sample'($urandom));
                    for (int k = 0; k < len && count < n; k++) begin
                        pending_samples.push_back(dcre_pkg::t_sample'(v));
                        count++;
                    end
                end
                6: begin
                    pending_samples.push_back($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000);
                    count++;
                end
                default: begin
                    pending_samples.push_back(dcre_pkg::t_sample'($urandom));
                    count++;
                end
            endcase
        end
    endtask

    task automatic run_phase(input dcre_pkg::t_taps d, input t_flow_mode mode, input int n);
        settle();
        write_taps(d);
        set_flow(mode);
        queue_random_samples(n, int'(d));
    endtask

    initial begin
        dcre_pkg::t_sample directed_samples[$];
        directed_samples = '{
            -16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1,
            16'sd21845, -16'sd21846, 16'sd100, 16'sd100, -16'sd5,
            16'sd32767, -16'sd32768, 16'sd0, 16'sd0, 16'sd2,
            16'sd21846, -16'sd21846, 16'sd101, 16'sd99, -16'sd4,
            16'sd32767, -16'sd32767, 16'sd1, 16'sd32767, -16'sd32768
        };

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_flow(FLOW_FREE);

        // Reset distance: warm-up, extremes, equal and closing samples
        foreach (directed_samples[k]) pending_samples.push_back(directed_samples[k]);

        run_phase(dcre_pkg::TAPS_RESET, FLOW_SEND_IDLE, 60);
        run_phase(5'd1, FLOW_RECV_STALL, 70);
        run_phase(5'd31, FLOW_BOTH, 70);
        // Zero distance: nothing may rise, an open rise still closes
        run_phase(5'd0, FLOW_FREE, 30);

        run_phase(5'd7, FLOW_SEND_IDLE, 70);
        run_phase(dcre_pkg::t_taps'($urandom_range(1, 31)), FLOW_RECV_STALL, 70);
        run_phase(5'd16, FLOW_BOTH, 70);
        run_phase(dcre_pkg::t_taps'($urandom_range(1, 31)), FLOW_FREE, 60);
        settle();

        $display("Covered %0d samples over %0d tap settings plus the reset distance.",
                 samples_taken, settings_used);
        $display("Checked %0d rise events, longest rise %0d samples, %0d mismatches.",
                 events_checked, longest_rise, mismatch_count);
        if (mismatch_count == 0 && expected_rises.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
